// ===== design/utf8f_pkg.sv =====
// utf8f_pkg: shared types, constants and fold tables for the utf-8 to ascii folder
// used by utf8f_front, utf8f_queue, utf8f_back and utf8_to_ascii_folder
// no dependencies
`default_nettype none

package utf8f_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [8:0] CAPACITY_RESET = 9'd32;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LEAD2   = 2'd1,
        PH_LEAD3   = 2'd2,
        PH_FOLLOW3 = 2'd3
    } phase_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       end_of_text;
    } word_t;

    typedef struct packed {
        logic  v0;
        logic  v1;
        word_t w0;
        word_t w1;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] ch;
    } fold_t;

    localparam logic [8*64-1:0] FOLD_LATIN1 =
        "AAAAAAACEEEEIIIIDNOOOOOxOUUUUYTsaaaaaaaceeeeiiiidnooooo/ouuuuyty";

    localparam logic [8*128-1:0] FOLD_EXT_A =
        {"AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIiIiJjKkkLlLlLlLlLlNnNnNn",
         "nNnOoOoOoOoRrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs"};

    function automatic logic [6:0] latin1_lookup(input logic [5:0] idx);
        int unsigned pos;
        pos = 8 * (63 - int'(idx));
        return FOLD_LATIN1[pos +: 7];
    endfunction

    function automatic logic [6:0] ext_a_lookup(input logic [6:0] idx);
        int unsigned pos;
        pos = 8 * (127 - int'(idx));
        return FOLD_EXT_A[pos +: 7];
    endfunction

    function automatic fold_t fold_point(input logic [15:0] cp);
        fold_t f;
        f.ok = 1'b0;
        f.ch = '0;
        if (cp < 16'h0080) begin
            f.ch = cp[6:0];
            f.ok = (cp >= 16'h0020);
        end else if (cp >= 16'h00C0 && cp <= 16'h00FF) begin
            f.ch = latin1_lookup(cp[5:0]);
            f.ok = (f.ch >= 7'h20);
        end else if (cp >= 16'h0100 && cp <= 16'h017F) begin
            f.ch = ext_a_lookup(cp[6:0]);
            f.ok = (f.ch >= 7'h20);
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== design/utf8f_front.sv =====
// utf8f_front: accepts input bytes, runs the utf-8 decode state and folds code points
// depends on utf8f_pkg; pushes up to two result words per byte into utf8f_queue
`default_nettype none

module utf8f_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [8:0]        cfg_wr_data,
    input  wire logic              s_valid,
    input  wire logic              space_ok,
    output logic                   s_ready,
    input  wire logic [7:0]        s_byte_in,
    output utf8f_pkg::push_t       push
);

    utf8f_pkg::phase_t phase_reg, phase_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] follow_reg, follow_next;
    logic [8:0] written_reg, written_next;
    logic [8:0] capacity_reg;

    logic              accept;
    logic              room;
    logic              emit;
    logic [15:0]       cp;
    utf8f_pkg::fold_t  fold;

    assign s_ready = space_ok;
    assign accept  = s_valid && space_ok;
    assign room    = ({1'b0, written_reg} + 10'd1) < {1'b0, capacity_reg};
    assign fold    = utf8f_pkg::fold_point(cp);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= utf8f_pkg::CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // code point selection and result words
    always_comb begin
        cp   = 16'h0000;
        emit = 1'b0;
        push = '0;
        if (s_byte_in == 8'h00) begin
            cp = {8'h00, follow_reg};
            if (phase_reg == utf8f_pkg::PH_FOLLOW3 && !follow_reg[7]) begin
                emit = fold.ok && room;
            end
            push.v0 = 1'b1;
            push.w0 = '{ascii_char: emit ? fold.ch : 7'h00, end_of_text: !emit};
            push.v1 = emit;
            push.w1 = '{ascii_char: 7'h00, end_of_text: 1'b1};
        end else if (room) begin
            unique case (phase_reg)
                utf8f_pkg::PH_LEAD2: begin
                    cp   = {5'h00, lead_reg[4:0], s_byte_in[5:0]};
                    emit = fold.ok;
                end
                utf8f_pkg::PH_FOLLOW3: begin
                    cp   = {lead_reg[3:0], follow_reg[5:0], s_byte_in[5:0]};
                    emit = fold.ok;
                end
                utf8f_pkg::PH_IDLE: begin
                    cp   = {8'h00, s_byte_in};
                    emit = fold.ok && !s_byte_in[7];
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
            push.v0 = emit;
            push.w0 = '{ascii_char: fold.ch, end_of_text: 1'b0};
        end
        if (!accept) begin
            push.v0 = 1'b0;
            push.v1 = 1'b0;
        end
    end

    // decode state
    always_comb begin
        phase_next   = phase_reg;
        lead_next    = lead_reg;
        follow_next  = follow_reg;
        written_next = written_reg;
        if (accept) begin
            if (s_byte_in == 8'h00) begin
                phase_next   = utf8f_pkg::PH_IDLE;
                written_next = '0;
            end else if (!room) begin
                phase_next = utf8f_pkg::PH_IDLE;
            end else begin
                unique case (phase_reg)
                    utf8f_pkg::PH_LEAD2, utf8f_pkg::PH_FOLLOW3: begin
                        phase_next = utf8f_pkg::PH_IDLE;
                    end
                    utf8f_pkg::PH_LEAD3: begin
                        follow_next = s_byte_in;
                        phase_next  = utf8f_pkg::PH_FOLLOW3;
                    end
                    default: begin
                        if (s_byte_in[7:5] == 3'b110) begin
                            lead_next  = s_byte_in;
                            phase_next = utf8f_pkg::PH_LEAD2;
                        end else if (s_byte_in[7:4] == 4'b1110) begin
                            lead_next  = s_byte_in;
                            phase_next = utf8f_pkg::PH_LEAD3;
                        end
                    end
                endcase
                if (emit) begin
                    written_next = written_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= utf8f_pkg::PH_IDLE;
            written_reg <= '0;
            lead_reg    <= '0;
            follow_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            written_reg <= written_next;
            lead_reg    <= lead_next;
            follow_reg  <= follow_next;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_byte_in == 8'h00) |=>
            (written_reg == 9'd0 && phase_reg == utf8f_pkg::PH_IDLE))
        else $error("terminator did not clear decode state");

    a_second_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> (push.v0 && push.w1.end_of_text && !push.w0.end_of_text))
        else $error("second word of a byte must be the end word");

    a_written_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && push.v0 && !push.w0.end_of_text) |-> room)
        else $error("character emitted without room");

endmodule

`default_nettype wire

// ===== design/utf8f_queue.sv =====
// utf8f_queue: short word queue between front and back, two pushes and one pop per cycle
// depends on utf8f_pkg
`default_nettype none

module utf8f_queue #(
    parameter int DEPTH = utf8f_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire utf8f_pkg::push_t  push,
    input  wire logic              pop,
    output utf8f_pkg::word_t       head,
    output logic                   empty,
    output logic                   space_ok
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utf8f_pkg::word_t slots_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_plus1;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_plus1 = ptr_inc(wr_reg);
    assign head     = slots_reg[rd_reg];
    assign empty    = (count_reg == '0);
    assign space_ok = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push.v0) begin
            wr_next = push.v1 ? ptr_inc(wr_plus1) : wr_plus1;
        end
        if (pop) begin
            rd_next = ptr_inc(rd_reg);
        end
        count_next = count_reg + CW'(push.v0) + CW'(push.v1) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            slots_reg[wr_reg] <= push.w0;
        end
        if (push.v1) begin
            slots_reg[wr_plus1] <= push.w1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== design/utf8f_back.sv =====
// utf8f_back: output register that drains the word queue onto the result channel
// depends on utf8f_pkg
`default_nettype none

module utf8f_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire utf8f_pkg::word_t  head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [6:0]             m_ascii_char,
    output logic                   m_end_of_text
);

    logic             valid_reg;
    utf8f_pkg::word_t word_reg;

    assign pop           = !empty && (!valid_reg || m_ready);
    assign m_valid       = valid_reg;
    assign m_ascii_char  = word_reg.ascii_char;
    assign m_end_of_text = word_reg.end_of_text;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg <= head;
        end
    end

    a_end_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && word_reg.end_of_text) |-> (word_reg.ascii_char == 7'h00))
        else $error("end word carries a character");

endmodule

`default_nettype wire

// ===== design/utf8_to_ascii_folder.sv =====
// utf8_to_ascii_folder: one byte in per cycle while the queue has space; a result is
// written to the queue and then to the output register before it is offered. a terminator
// that also releases a held character yields two words.
// the four-word queue between decode front and output register bounds the backlog.
// synchronous active-low reset clears decode state and queue; capacity returns to 32.
// depends on utf8f_pkg, utf8f_front, utf8f_queue, utf8f_back
`default_nettype none

module utf8_to_ascii_folder #(
    parameter int QUEUE_DEPTH = utf8f_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_ascii_char,
    output logic             m_end_of_text
);

    utf8f_pkg::push_t push;
    utf8f_pkg::word_t head;
    logic empty;
    logic space_ok;
    logic pop;

    utf8f_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .space_ok    (space_ok),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .push        (push)
    );

    utf8f_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .space_ok (space_ok)
    );

    utf8f_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_char  (m_ascii_char),
        .m_end_of_text (m_end_of_text)
    );

endmodule

`default_nettype wire
